// ----- hw/rtl/dma_expansion_ram_controller_core_assert.svh -----
// assertion macros shared by the expansion ram dma controller
`ifndef DMA_EXPANSION_RAM_CONTROLLER_CORE_ASSERT_SVH
`define DMA_EXPANSION_RAM_CONTROLLER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define DXC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked during reset as well
`define DXC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DXC_ASSERT(lbl, prop, msg)
`define DXC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/dxc_pkg.sv -----
// types, codes and constants of the expansion ram dma controller
package dxc_pkg;

  localparam int unsigned DxcMaxRamBytes = 524288;
  localparam int unsigned DxcQueueDepth  = 2;

  // operation codes, equal to the func field codes
  typedef enum logic [2:0] {
    OP_RD    = 3'd0,
    OP_WR    = 3'd1,
    OP_TRIG  = 3'd2,
    OP_HDATA = 3'd3,
    OP_TICK  = 3'd4
  } op_e;

  // result kinds
  localparam logic [1:0] KIND_REG_DATA  = 2'd0;
  localparam logic [1:0] KIND_HOST_READ = 2'd1;
  localparam logic [1:0] KIND_HOST_WRITE = 2'd2;

  // transfer modes, command bits 1:0
  localparam logic [1:0] MODE_TO_RAM  = 2'd0;
  localparam logic [1:0] MODE_TO_HOST = 2'd1;
  localparam logic [1:0] MODE_SWAP    = 2'd2;
  localparam logic [1:0] MODE_VERIFY  = 2'd3;

  // register map
  localparam logic [3:0] REG_STATUS  = 4'd0;
  localparam logic [3:0] REG_CMD     = 4'd1;
  localparam logic [3:0] REG_HADDR_L = 4'd2;
  localparam logic [3:0] REG_HADDR_H = 4'd3;
  localparam logic [3:0] REG_EADDR_L = 4'd4;
  localparam logic [3:0] REG_EADDR_H = 4'd5;
  localparam logic [3:0] REG_BANK    = 4'd6;
  localparam logic [3:0] REG_LEN_L   = 4'd7;
  localparam logic [3:0] REG_LEN_H   = 4'd8;
  localparam logic [3:0] REG_IRQ     = 4'd9;
  localparam logic [3:0] REG_ACTL    = 4'd10;

  // one queued input word
  typedef struct packed {
    op_e        op;
    logic [4:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] float_byte;
    logic [7:0] host_data;
  } entry_t;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  read_data;
    logic [15:0] host_addr;
    logic [7:0]  host_wdata;
    logic        busy;
  } result_t;

  // codes beyond the dma tick carry no operation
  function automatic logic func_known(logic [2:0] func);
    return func <= 3'(OP_TICK);
  endfunction

endpackage

// ----- hw/rtl/dxc_ram.sv -----
// generic single-write, single-read ram with registered read data
module dxc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/dxc_fifo.sv -----
// small word queue between the front, the back and the result side
module dxc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ----- hw/rtl/dxc_back.sv -----
// back end: register file, transfer engine and expansion ram sweep
`include "dma_expansion_ram_controller_core_assert.svh"
module dxc_back import dxc_pkg::*; #(
  parameter int unsigned MAX_RAM_BYTES = DxcMaxRamBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_size_i,
  input  logic       q_valid_i,
  input  entry_t     q_entry_i,
  output logic       q_pop_o,
  input  logic       res_full_i,
  output logic       res_push_o,
  output result_t    res_o,
  output logic       clearing_o
);

  localparam int unsigned AW = $clog2(MAX_RAM_BYTES);
  localparam logic [23:0] MaxMask = 24'(MAX_RAM_BYTES - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;

  // expansion address mask for a size selection, clipped to the fitted ram
  function automatic logic [23:0] size_mask(logic [1:0] sel);
    logic [23:0] m;
    case (sel)
      2'd1:    m = 24'h01ffff;
      2'd2:    m = 24'h03ffff;
      2'd3:    m = 24'h07ffff;
      default: m = 24'h000000;
    endcase
    return m & MaxMask;
  endfunction

  logic [1:0]  state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [1:0]  size_q, size_d;
  logic [7:0]  status_q, status_d, cmd_q, cmd_d, irq_q, irq_d, actl_q, actl_d;
  logic [15:0] haddr_q, haddr_d, len_q, len_d, sh_h_q, sh_h_d, sh_l_q, sh_l_d;
  logic [23:0] eaddr_q, eaddr_d, sh_e_q, sh_e_d;
  logic        busy_q, busy_d, pend_q, pend_d;
  logic        w_tick_q, w_tick_d;
  logic [7:0]  w_hd_q, w_hd_d;

  logic [23:0] mask;
  logic        present;
  logic [AW-1:0] idx;
  logic [1:0]  mode;
  logic        ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic        do_adv, mism, fin, push;
  logic [1:0]  r_kind;
  logic [7:0]  r_rdata, r_wdata, rd_val;
  logic [15:0] r_haddr;

  assign mask    = size_mask(size_q);
  assign present = (size_q != 2'd0);
  assign idx     = eaddr_q[AW-1:0] & mask[AW-1:0];
  assign mode    = cmd_q[1:0];
  assign clearing_o = (state_q == ST_CLEAR);

  dxc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_RAM_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(idx),
    .rdata_o(ram_rdata)
  );

  // register read mux
  always_comb begin
    if (q_entry_i.reg_addr[4]) begin
      rd_val = 8'hff;
    end else begin
      unique case (q_entry_i.reg_addr[3:0])
        REG_STATUS:  rd_val = status_q;
        REG_CMD:     rd_val = cmd_q;
        REG_HADDR_L: rd_val = haddr_q[7:0];
        REG_HADDR_H: rd_val = haddr_q[15:8];
        REG_EADDR_L: rd_val = eaddr_q[7:0];
        REG_EADDR_H: rd_val = eaddr_q[15:8];
        REG_BANK:    rd_val = eaddr_q[23:16] | 8'hf8;
        REG_LEN_L:   rd_val = len_q[7:0];
        REG_LEN_H:   rd_val = len_q[15:8];
        REG_IRQ:     rd_val = irq_q | 8'h1f;
        REG_ACTL:    rd_val = actl_q | 8'h3f;
        default:     rd_val = 8'hff;
      endcase
    end
  end

  // sequencer and register next state
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    size_d   = size_q;
    status_d = status_q;
    cmd_d    = cmd_q;
    irq_d    = irq_q;
    actl_d   = actl_q;
    haddr_d  = haddr_q;
    len_d    = len_q;
    sh_h_d   = sh_h_q;
    sh_l_d   = sh_l_q;
    eaddr_d  = eaddr_q;
    sh_e_d   = sh_e_q;
    busy_d   = busy_q;
    pend_d   = pend_q;
    w_tick_d = w_tick_q;
    w_hd_d   = w_hd_q;
    q_pop_o  = 1'b0;
    ram_we   = 1'b0;
    ram_waddr = idx;
    ram_wdata = q_entry_i.host_data;
    do_adv   = 1'b0;
    mism     = 1'b0;
    fin      = 1'b0;
    push     = 1'b0;
    r_kind   = KIND_REG_DATA;
    r_rdata  = 8'h00;
    r_haddr  = 16'h0000;
    r_wdata  = 8'h00;

    unique case (state_q)
      ST_CLEAR: begin
        // zero the ram one byte a cycle
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = 8'h00;
        clr_d     = clr_q + AW'(1);
        if (clr_q == {AW{1'b1}}) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (q_valid_i && !res_full_i) begin
          q_pop_o = 1'b1;
          case (q_entry_i.op)
            OP_RD: begin
              push    = 1'b1;
              r_rdata = present ? rd_val : q_entry_i.float_byte;
              if (present && q_entry_i.reg_addr == 5'(REG_STATUS)) begin
                status_d = status_q & 8'h1f;
              end
            end
            OP_WR: begin
              if (present && !busy_q && !q_entry_i.reg_addr[4]) begin
                unique case (q_entry_i.reg_addr[3:0])
                  REG_CMD: begin
                    cmd_d = q_entry_i.write_data;
                    if (q_entry_i.write_data[7] && q_entry_i.write_data[4]) begin
                      cmd_d[7] = 1'b0;
                      busy_d   = 1'b1;
                      pend_d   = 1'b0;
                    end
                  end
                  REG_HADDR_L: begin
                    sh_h_d  = {sh_h_q[15:8], q_entry_i.write_data};
                    haddr_d = {sh_h_q[15:8], q_entry_i.write_data};
                  end
                  REG_HADDR_H: begin
                    sh_h_d  = {q_entry_i.write_data, sh_h_q[7:0]};
                    haddr_d = {q_entry_i.write_data, sh_h_q[7:0]};
                  end
                  REG_EADDR_L: begin
                    sh_e_d  = {sh_e_q[23:8], q_entry_i.write_data};
                    eaddr_d = {eaddr_q[23:16], sh_e_q[15:8], q_entry_i.write_data};
                  end
                  REG_EADDR_H: begin
                    sh_e_d  = {sh_e_q[23:16], q_entry_i.write_data, sh_e_q[7:0]};
                    eaddr_d = {eaddr_q[23:16], q_entry_i.write_data, sh_e_q[7:0]};
                  end
                  REG_BANK: begin
                    sh_e_d  = {q_entry_i.write_data, sh_e_q[15:0]};
                    eaddr_d = {q_entry_i.write_data, eaddr_q[15:0]};
                  end
                  REG_LEN_L: begin
                    sh_l_d = {sh_l_q[15:8], q_entry_i.write_data};
                    len_d  = {sh_l_q[15:8], q_entry_i.write_data};
                  end
                  REG_LEN_H: begin
                    sh_l_d = {q_entry_i.write_data, sh_l_q[7:0]};
                    len_d  = {q_entry_i.write_data, sh_l_q[7:0]};
                  end
                  REG_IRQ:  irq_d  = q_entry_i.write_data;
                  REG_ACTL: actl_d = q_entry_i.write_data;
                  default: ;
                endcase
              end
            end
            OP_TRIG: begin
              if (present && !busy_q && cmd_q[7] && !cmd_q[4]) begin
                cmd_d  = {1'b0, cmd_q[6:5], 1'b1, cmd_q[3:0]};
                busy_d = 1'b1;
                pend_d = 1'b0;
              end
            end
            OP_TICK: begin
              if (busy_q && !pend_q) begin
                if (mode == MODE_TO_HOST) begin
                  state_d  = ST_WAIT;
                  w_tick_d = 1'b1;
                end else begin
                  push    = 1'b1;
                  r_kind  = KIND_HOST_READ;
                  r_haddr = haddr_q;
                  pend_d  = 1'b1;
                end
              end
            end
            OP_HDATA: begin
              if (busy_q && pend_q) begin
                pend_d = 1'b0;
                case (mode)
                  MODE_TO_RAM: begin
                    ram_we = 1'b1;
                    do_adv = 1'b1;
                  end
                  MODE_SWAP, MODE_VERIFY: begin
                    state_d  = ST_WAIT;
                    w_tick_d = 1'b0;
                    w_hd_d   = q_entry_i.host_data;
                  end
                  default: do_adv = 1'b1;
                endcase
              end
            end
            default: ;
          endcase
        end
      end
      ST_WAIT: begin
        // ram byte is now on the read port
        state_d = ST_EXEC;
        do_adv  = 1'b1;
        if (w_tick_q || mode == MODE_SWAP) begin
          push    = 1'b1;
          r_kind  = KIND_HOST_WRITE;
          r_haddr = haddr_q;
          r_wdata = ram_rdata;
          if (!w_tick_q) begin
            ram_we    = 1'b1;
            ram_wdata = w_hd_q;
          end
        end else if (ram_rdata != w_hd_q) begin
          mism     = 1'b1;
          status_d = status_d | 8'h20;
        end
      end
      default: state_d = ST_EXEC;
    endcase

    // address step, length count and end of transfer
    if (do_adv) begin
      if (!actl_q[7]) haddr_d = haddr_q + 16'd1;
      if (!actl_q[6]) eaddr_d = eaddr_q + 24'd1;
      if (len_q == 16'd1) begin
        status_d = status_d | 8'h40;
        fin      = 1'b1;
      end else begin
        len_d = len_q - 16'd1;
        fin   = mism;
      end
    end
    if (fin) begin
      busy_d = 1'b0;
      pend_d = 1'b0;
      if (cmd_q[5]) begin
        haddr_d = sh_h_q;
        eaddr_d = sh_e_q;
        len_d   = sh_l_q;
      end else begin
        eaddr_d = eaddr_d & mask;
      end
    end

    // size selection
    if (cfg_we_i) begin
      size_d      = cfg_size_i;
      status_d[4] = (size_mask(cfg_size_i) > 24'h01ffff);
      if (cfg_size_i == 2'd0) begin
        busy_d = 1'b0;
        pend_d = 1'b0;
      end
    end
  end

  assign res_push_o = push;
  assign res_o = '{kind: r_kind, read_data: r_rdata, host_addr: r_haddr,
                   host_wdata: r_wdata, busy: busy_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      size_q   <= 2'd3;
      status_q <= {3'b000, (size_mask(2'd3) > 24'h01ffff), 4'h0};
      cmd_q    <= 8'h10;
      irq_q    <= 8'h00;
      actl_q   <= 8'h00;
      haddr_q  <= 16'h0000;
      len_q    <= 16'hffff;
      sh_h_q   <= 16'h0000;
      sh_l_q   <= 16'hffff;
      eaddr_q  <= 24'h000000;
      sh_e_q   <= 24'h000000;
      busy_q   <= 1'b0;
      pend_q   <= 1'b0;
      w_tick_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      size_q   <= size_d;
      status_q <= status_d;
      cmd_q    <= cmd_d;
      irq_q    <= irq_d;
      actl_q   <= actl_d;
      haddr_q  <= haddr_d;
      len_q    <= len_d;
      sh_h_q   <= sh_h_d;
      sh_l_q   <= sh_l_d;
      eaddr_q  <= eaddr_d;
      sh_e_q   <= sh_e_d;
      busy_q   <= busy_d;
      pend_q   <= pend_d;
      w_tick_q <= w_tick_d;
    end
  end

  // held host byte needs no reset
  always_ff @(posedge clk_i) begin
    w_hd_q <= w_hd_d;
  end

  `DXC_ASSERT(a_pend_busy, pend_q |-> busy_q, "host read pending with no transfer")
  `DXC_ASSERT(a_wait_one, (state_q == ST_WAIT) |=> (state_q == ST_EXEC), "ram wait overran")
  `DXC_ASSERT(a_push_room, res_push_o |-> !res_full_i, "result pushed into full queue")
  `DXC_ASSERT_ALWAYS(a_clear_idle, (state_q == ST_CLEAR) |-> (!q_pop_o && !res_push_o),
                     "word taken during ram clear")

endmodule

// ----- hw/rtl/dma_expansion_ram_controller_core.sv -----
// Expansion ram dma controller. After reset the expansion ram is zeroed one byte a cycle,
// with full held high. Then the back end takes queued words while the result queue has room;
// a ram-to-host tick and the data word of a swap or verify pass a wait state, as the ram's
// read port is registered. Two-entry queues sit on input and result sides.
module dma_expansion_ram_controller_core import dxc_pkg::*; #(
  parameter int unsigned MAX_RAM_BYTES = DxcMaxRamBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  ram_size_select_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  func_i,
  input  logic [4:0]  reg_addr_i,
  input  logic [7:0]  write_data_i,
  input  logic [7:0]  float_byte_i,
  input  logic [7:0]  host_data_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  read_data_o,
  output logic [15:0] host_addr_o,
  output logic [7:0]  host_wdata_o,
  output logic        busy_res_o
);

  logic    in_full, q_valid, q_empty, q_pop, clearing, res_full, res_push;
  entry_t  in_entry, q_entry;
  result_t res_in, res_out;

  assign cfg_ready_o = 1'b1;

  // front: unknown function codes are dropped, the rest queued
  assign full     = in_full || clearing;
  assign in_entry = '{op: op_e'(func_i), reg_addr: reg_addr_i, write_data: write_data_i,
                      float_byte: float_byte_i, host_data: host_data_i};

  dxc_fifo #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DxcQueueDepth)
  ) u_in_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push && !full && func_known(func_i)),
    .wdata_i(in_entry),
    .full_o (in_full),
    .pop_i  (q_pop),
    .rdata_o(q_entry),
    .empty_o(q_empty)
  );

  assign q_valid = !q_empty;

  dxc_back #(
    .MAX_RAM_BYTES(MAX_RAM_BYTES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_valid_i && cfg_ready_o),
    .cfg_size_i(ram_size_select_i),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_pop_o   (q_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_in),
    .clearing_o(clearing)
  );

  // result queue
  dxc_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(DxcQueueDepth)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .wdata_i(res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .rdata_o(res_out),
    .empty_o(empty)
  );

  assign kind_o       = res_out.kind;
  assign read_data_o  = res_out.read_data;
  assign host_addr_o  = res_out.host_addr;
  assign host_wdata_o = res_out.host_wdata;
  assign busy_res_o   = res_out.busy;

endmodule
